>>> rtl/swe_pkg.sv
// Shared types, register indexes and defaults for the scan side width estimator.
package swe_pkg;

	// Default for the per-side point limit
	localparam int MAX_POINTS_DEF = 1024;

	// Depth of the queue between the front and back ends
	localparam int QUEUE_DEPTH = 2;

	// Field widths
	localparam int COORD_W = 16;
	localparam int UCFG_W  = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HALF_HEIGHT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIPOD_HALF_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRIPOD_TOP          = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRIPOD_FLOOR_MARGIN = 2'd3;

	// Reset values of the configuration registers
	localparam logic [UCFG_W-1:0]  BAND_RST   = 15'd100;
	localparam logic [UCFG_W-1:0]  HW_RST     = 15'd400;
	localparam logic [COORD_W-1:0] TOP_RST    = 16'd50;
	localparam logic [UCFG_W-1:0]  MARGIN_RST = 15'd50;

	// Classification settings seen by the front end
	typedef struct packed {
		logic [UCFG_W-1:0]         band_half_height;
		logic [UCFG_W-1:0]         tripod_half_width;
		logic signed [COORD_W-1:0] tripod_top;
		logic [UCFG_W-1:0]         tripod_floor_margin;
	} cfg_t;

	// Queue status toward the back end
	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

endpackage

>>> rtl/swe_front.sv
// Front end: classifies points and accumulates per-side sums and counts.
module swe_front #(
	parameter int MAX_POINTS = swe_pkg::MAX_POINTS_DEF,
	parameter int CW = $clog2(MAX_POINTS + 1),
	parameter int SW = CW + 15
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swe_pkg::cfg_t                  cfg,
	input  logic                           accept,
	input  logic [swe_pkg::COORD_W-1:0]    point_y,
	input  logic [swe_pkg::COORD_W-1:0]    point_z,
	input  logic [swe_pkg::COORD_W-1:0]    scan_floor,
	input  logic                           last_point,
	output logic                           push,
	output logic [2*(SW+CW)-1:0]           push_data
);

	logic [SW-1:0] lsum_q, rsum_q, lsum_nxt, rsum_nxt;
	logic [CW-1:0] lcnt_q, rcnt_q, lcnt_nxt, rcnt_nxt;

	logic signed [17:0] floor_lim;
	logic signed [17:0] z18;
	logic signed [16:0] y17, z17, hw17, band17;
	logic               in_tripod, in_band, y_pos, y_neg;
	logic [15:0]        y_mag;

	// Tripod zone and height band tests
	always_comb begin
		z18       = $signed({{2{point_z[15]}}, point_z});
		floor_lim = $signed({{2{scan_floor[15]}}, scan_floor})
			- $signed({3'b000, cfg.tripod_floor_margin});
		y17       = $signed({point_y[15], point_y});
		z17       = $signed({point_z[15], point_z});
		hw17      = $signed({2'b00, cfg.tripod_half_width});
		band17    = $signed({2'b00, cfg.band_half_height});
		in_tripod = (z18 > floor_lim) && ($signed(point_z) < cfg.tripod_top)
			&& (y17 <= hw17) && (y17 >= -hw17);
		in_band   = !in_tripod && (z17 > -band17) && (z17 < band17);
		y_pos     = !point_y[15] && (point_y != '0);
		y_neg     = point_y[15];
		y_mag     = 16'(~point_y + 16'd1);
	end

	// Next accumulator values, including the current point
	always_comb begin
		lsum_nxt = lsum_q;
		lcnt_nxt = lcnt_q;
		rsum_nxt = rsum_q;
		rcnt_nxt = rcnt_q;
		if (in_band && y_pos && (lcnt_q < CW'(MAX_POINTS))) begin
			lsum_nxt = lsum_q + SW'(point_y[14:0]);
			lcnt_nxt = lcnt_q + CW'(1);
		end else if (in_band && y_neg && (rcnt_q < CW'(MAX_POINTS))) begin
			rsum_nxt = rsum_q + SW'(y_mag);
			rcnt_nxt = rcnt_q + CW'(1);
		end
	end

	assign push      = accept && last_point;
	assign push_data = {rcnt_nxt, rsum_nxt, lcnt_nxt, lsum_nxt};

	// Accumulators, cleared once a scan is handed to the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q <= '0;
			rsum_q <= '0;
			lcnt_q <= '0;
			rcnt_q <= '0;
		end else if (accept) begin
			if (last_point) begin
				lsum_q <= '0;
				rsum_q <= '0;
				lcnt_q <= '0;
				rcnt_q <= '0;
			end else begin
				lsum_q <= lsum_nxt;
				rsum_q <= rsum_nxt;
				lcnt_q <= lcnt_nxt;
				rcnt_q <= rcnt_nxt;
			end
		end
	end

endmodule

>>> rtl/swe_queue.sv
// Small FIFO holding finished scan totals between front and back ends.
module swe_queue #(
	parameter int W = 8,
	parameter int DEPTH = swe_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [W-1:0]           push_data,
	input  logic                   pop,
	output logic [W-1:0]           pop_data,
	output swe_pkg::queue_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] cnt_q;

	assign status.full      = (cnt_q == NW'(DEPTH));
	assign status.not_empty = (cnt_q != '0);
	assign pop_data         = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

>>> rtl/swe_div.sv
// Restoring divider, one quotient bit per cycle.
module swe_div #(
	parameter int DW = 27,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int NW = $clog2(DW + 1);

	logic [DW-1:0] a_q;
	logic [VW-1:0] rem_q, d_q, rem_nxt;
	logic [NW-1:0] cnt_q;
	logic          busy_q, done_q, ge;
	logic [VW:0]   trial, diff;

	// One restoring step
	always_comb begin
		trial   = {rem_q, a_q[DW-1]};
		diff    = trial - {1'b0, d_q};
		ge      = (trial >= {1'b0, d_q});
		rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
	end

	assign done     = done_q;
	assign quotient = a_q;

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			a_q   <= {a_q[DW-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == NW'(DW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NW'(1);
				if (cnt_q == NW'(DW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> rtl/swe_back.sv
// Back end: rounded side means, width, running minimum and output register.
module swe_back #(
	parameter int CW = 11,
	parameter int SW = 26
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  swe_pkg::queue_status_t qstat,
	input  logic [2*(SW+CW)-1:0]   entry,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [63:0]            out_data,
	output logic [1:0]             out_flags
);

	localparam int DW = SW + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LST   = 3'd1;
	localparam logic [2:0] S_LWAIT = 3'd2;
	localparam logic [2:0] S_RST   = 3'd3;
	localparam logic [2:0] S_RWAIT = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]    state_q;
	logic [SW-1:0] lsum_q, rsum_q;
	logic [CW-1:0] lcnt_q, rcnt_q;
	logic [14:0]   lmean_q;
	logic [15:0]   rmag_q;
	logic [15:0]   min_q;
	logic          out_valid_q;
	logic [63:0]   out_data_q;
	logic [1:0]    out_flags_q;

	logic          div_start, div_done;
	logic [DW-1:0] div_dividend, div_quot;
	logic [CW-1:0] div_divisor;
	logic          lempty, rempty, out_free;
	logic [15:0]   width, rmean, min_nxt;

	assign lempty   = (lcnt_q == '0);
	assign rempty   = (rcnt_q == '0);
	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == S_IDLE) && qstat.not_empty;

	// Divider operand select: left side first, then right
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DW'(lsum_q) + DW'(lcnt_q >> 1);
		div_divisor  = lcnt_q;
		if (state_q == S_LST) begin
			div_start = !lempty;
		end else if (state_q == S_RST) begin
			div_start    = !rempty;
			div_dividend = DW'(rsum_q) + DW'(rcnt_q >> 1);
			div_divisor  = rcnt_q;
		end
	end

	swe_div #(
		.DW(DW),
		.VW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quot)
	);

	// Width and minimum
	always_comb begin
		rmean   = 16'(~rmag_q + 16'd1);
		width   = (lempty || rempty) ? 16'd0 : ({1'b0, lmean_q} + rmag_q);
		min_nxt = (!lempty && !rempty && (width < min_q)) ? width : min_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_flags = out_flags_q;

	// Scan totals and means
	always_ff @(posedge clk) begin
		if (pop) begin
			{rcnt_q, rsum_q, lcnt_q, lsum_q} <= entry;
		end
		if (state_q == S_LST) begin
			lmean_q <= '0;
		end else if (state_q == S_LWAIT && div_done) begin
			lmean_q <= div_quot[14:0];
		end
		if (state_q == S_RST) begin
			rmag_q <= '0;
		end else if (state_q == S_RWAIT && div_done) begin
			rmag_q <= div_quot[15:0];
		end
		if (state_q == S_FIN && out_free) begin
			out_data_q  <= {1'b0, min_nxt, width, rmean, lmean_q};
			out_flags_q <= {rempty, lempty};
		end
	end

	// Sequencer, minimum register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_q       <= 16'hFFFF;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (qstat.not_empty) begin
						state_q <= S_LST;
					end
				end
				S_LST: begin
					state_q <= lempty ? S_RST : S_LWAIT;
				end
				S_LWAIT: begin
					if (div_done) begin
						state_q <= S_RST;
					end
				end
				S_RST: begin
					state_q <= rempty ? S_FIN : S_RWAIT;
				end
				S_RWAIT: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						min_q   <= min_nxt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/scan_side_width_estimator_top.sv
// Top level of the scan side width estimator.
//
// Input stream (s_axis): one laser point per transaction, y, z and the scan
// floor in tdata, tlast marking the final point of a scan. Points outside the
// tripod zone and inside the height band are summed per side, one point per
// cycle. The final point is counted, then the scan totals move into a
// two-entry queue and the accumulators clear at once, so the next scan can
// stream in without a gap.
// Output stream (m_axis): one transaction per scan with both rounded side
// means, the width and the running minimum width in tdata, empty-side flags
// in tuser. The back end runs one restoring divider (one quotient bit per
// cycle) for each non-empty side. Points are accepted every cycle while
// the queue has room; a scan shorter than the back end's time per scan
// throttles s_axis_tready. When the receiver stalls, the result holds in
// the output register; the back end finishes the next scan and then waits,
// and the queue fills behind it. Reset clears the accumulators, the queue,
// the minimum width (to 65535) and loads the default configuration.
// Configuration must be written only while idle; the block itself does not
// enforce this.
module scan_side_width_estimator_top #(
	parameter int MAX_POINTS = swe_pkg::MAX_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [swe_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [swe_pkg::CFG_DATA_W-1:0]     cfg_data,
	// point stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // point_y[15:0], point_z[31:16], scan_floor[47:32]
	input  logic        s_axis_tlast,   // last_point
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // left_mean[14:0], right_mean[30:15],
	                                    // scan_width[46:31], min_width[62:47], pad
	output logic [1:0]  m_axis_tuser    // left_empty[0], right_empty[1]
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = CW + 15;
	localparam int EW = 2 * (SW + CW);

	swe_pkg::cfg_t          cfg_q;
	swe_pkg::queue_status_t qstat;
	logic                   accept, push, pop;
	logic [EW-1:0]          push_data, pop_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_half_height    <= swe_pkg::BAND_RST;
			cfg_q.tripod_half_width   <= swe_pkg::HW_RST;
			cfg_q.tripod_top          <= swe_pkg::TOP_RST;
			cfg_q.tripod_floor_margin <= swe_pkg::MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				swe_pkg::REG_BAND_HALF_HEIGHT:    cfg_q.band_half_height    <= cfg_data[14:0];
				swe_pkg::REG_TRIPOD_HALF_WIDTH:   cfg_q.tripod_half_width   <= cfg_data[14:0];
				swe_pkg::REG_TRIPOD_TOP:          cfg_q.tripod_top          <= cfg_data;
				swe_pkg::REG_TRIPOD_FLOOR_MARGIN: cfg_q.tripod_floor_margin <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	assign s_axis_tready = !qstat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	swe_front #(
		.MAX_POINTS(MAX_POINTS),
		.CW        (CW),
		.SW        (SW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.point_y   (s_axis_tdata[15:0]),
		.point_z   (s_axis_tdata[31:16]),
		.scan_floor(s_axis_tdata[47:32]),
		.last_point(s_axis_tlast),
		.push      (push),
		.push_data (push_data)
	);

	swe_queue #(
		.W    (EW),
		.DEPTH(swe_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.status   (qstat)
	);

	swe_back #(
		.CW(CW),
		.SW(SW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.entry    (pop_data),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_flags(m_axis_tuser)
	);

`ifndef ASSERT_OFF
	// An empty side forces a zero width
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != 2'b00) |-> m_axis_tdata[46:31] == 16'd0)
		else $error("width nonzero with an empty side");

	// The running minimum never exceeds a valid width
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == 2'b00) |-> m_axis_tdata[62:47] <= m_axis_tdata[46:31])
		else $error("minimum width above current width");

	// A non-empty left side has a nonzero mean
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[14:0] != 15'd0)
		else $error("left mean zero for a non-empty side");
`endif

endmodule
